>>> hdl/ccch_pkg.sv
// shared codes and the reply descriptor type for the control channel command handler
package ccch_pkg;

  localparam logic [7:0] TYPE_CONTROL = 8'h01;
  localparam logic [7:0] TYPE_QUERY   = 8'h02;
  localparam logic [7:0] TYPE_CONFIG  = 8'h03;
  localparam logic [7:0] REPLY_STATUS = 8'h04;
  localparam logic [7:0] REPLY_ACK    = 8'h05;

  localparam logic [15:0] CFG_LEN_RESET = 16'd512;

  localparam int STAT_W = 5;
  localparam logic [STAT_W-1:0] STAT_BUSY   = 5'(1 << 0);
  localparam logic [STAT_W-1:0] STAT_READY  = 5'(1 << 1);
  localparam logic [STAT_W-1:0] STAT_ERROR  = 5'(1 << 2);
  localparam logic [STAT_W-1:0] STAT_IMAGE  = 5'(1 << 3);
  localparam logic [STAT_W-1:0] STAT_CONFIG = 5'(1 << 4);

  localparam int CTRL_RESET_BIT   = 0;
  localparam int CTRL_TRIGGER_BIT = 1;

  localparam logic [15:0] FAIL_ADDR = 16'h0001;

  localparam int REPLY_LEN = 5;
  localparam int IDX_W     = $clog2(REPLY_LEN);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one queued reply: the back end expands it into five words
  typedef struct packed {
    logic              is_ack;
    logic              start;
    logic [STAT_W-1:0] bits;
    logic              err;
  } reply_t;

endpackage

>>> hdl/ccch_front.sv
// message parser: tracks flags and builds one reply descriptor per finished message
module ccch_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_accept,
  input  logic            req_type,
  input  logic [7:0]      rx_byte,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_data,
  output logic            push,
  output ccch_pkg::reply_t entry
);
  import ccch_pkg::*;

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_CTRL0   = 4'd1;
  localparam logic [3:0] PH_CTRL1   = 4'd2;
  localparam logic [3:0] PH_QRY0    = 4'd3;
  localparam logic [3:0] PH_QRY1    = 4'd4;
  localparam logic [3:0] PH_LEN0    = 4'd5;
  localparam logic [3:0] PH_LEN1    = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_HALT    = 4'd8;

  logic [15:0] expected_len;
  logic [3:0]  phase, phase_next;
  logic [7:0]  held_low, held_low_next;
  logic [15:0] payload_left, payload_left_next;
  logic        length_matched, length_matched_next;
  logic        cfg_applied, cfg_applied_next;
  logic        frame_ready, frame_ready_next;
  logic        busy, busy_next;
  logic        error, error_next;

  logic [15:0] len_now;
  logic        match_now;

  function automatic logic [STAT_W-1:0] status_bits(input logic b, input logic e,
                                                   input logic im, input logic c);
    logic [STAT_W-1:0] s;
    s = b ? STAT_BUSY : STAT_READY;
    if (e)  s = s | STAT_ERROR;
    if (im) s = s | STAT_IMAGE;
    if (c)  s = s | STAT_CONFIG;
    return s;
  endfunction

  assign len_now   = {rx_byte, held_low};
  assign match_now = (len_now == expected_len);

  always_comb begin
    phase_next          = phase;
    held_low_next       = held_low;
    payload_left_next   = payload_left;
    length_matched_next = length_matched;
    cfg_applied_next    = cfg_applied;
    frame_ready_next    = frame_ready;
    busy_next           = busy;
    error_next          = error;
    push                = 1'b0;
    entry               = '0;

    if (in_accept && phase != PH_HALT) begin
      if (req_type) begin
        frame_ready_next = 1'b1;
        busy_next        = 1'b0;
      end else begin
        case (phase)
          PH_IDLE: begin
            case (rx_byte)
              TYPE_CONTROL: phase_next = PH_CTRL0;
              TYPE_QUERY:   phase_next = PH_QRY0;
              TYPE_CONFIG:  phase_next = PH_LEN0;
              default:      phase_next = PH_HALT;
            endcase
          end
          PH_CTRL0: begin
            held_low_next = rx_byte;
            phase_next    = PH_CTRL1;
          end
          PH_CTRL1: begin
            // reset bit goes first, then trigger
            if (held_low[CTRL_RESET_BIT]) begin
              cfg_applied_next = 1'b0;
              frame_ready_next = 1'b0;
              busy_next        = 1'b0;
              error_next       = 1'b0;
            end
            if (held_low[CTRL_TRIGGER_BIT]) begin
              frame_ready_next = 1'b0;
              busy_next        = 1'b1;
            end
            push         = 1'b1;
            entry.is_ack = 1'b0;
            entry.start  = held_low[CTRL_TRIGGER_BIT];
            entry.bits   = status_bits(busy_next, error_next, frame_ready_next,
                                       cfg_applied_next);
            entry.err    = error_next;
            phase_next   = PH_IDLE;
          end
          PH_QRY0: phase_next = PH_QRY1;
          PH_QRY1: begin
            push         = 1'b1;
            entry.is_ack = 1'b0;
            entry.start  = 1'b0;
            entry.bits   = status_bits(busy, error, frame_ready, cfg_applied);
            entry.err    = error;
            phase_next   = PH_IDLE;
          end
          PH_LEN0: begin
            held_low_next = rx_byte;
            phase_next    = PH_LEN1;
          end
          PH_LEN1: begin
            payload_left_next   = len_now;
            length_matched_next = match_now;
            if (len_now == 16'd0) begin
              push             = 1'b1;
              entry.is_ack     = 1'b1;
              entry.bits       = {{(STAT_W-1){1'b0}}, ~match_now};
              entry.err        = ~match_now & FAIL_ADDR[0];
              cfg_applied_next = match_now;
              error_next       = ~match_now;
              phase_next       = PH_IDLE;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            payload_left_next = payload_left - 16'd1;
            if (payload_left_next == 16'd0) begin
              push             = 1'b1;
              entry.is_ack     = 1'b1;
              entry.bits       = {{(STAT_W-1){1'b0}}, ~length_matched};
              entry.err        = ~length_matched & FAIL_ADDR[0];
              cfg_applied_next = length_matched;
              error_next       = ~length_matched;
              phase_next       = PH_IDLE;
            end
          end
          default: phase_next = PH_HALT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_len   <= CFG_LEN_RESET;
      phase          <= PH_IDLE;
      held_low       <= '0;
      payload_left   <= '0;
      length_matched <= 1'b0;
      cfg_applied    <= 1'b0;
      frame_ready    <= 1'b0;
      busy           <= 1'b0;
      error          <= 1'b0;
    end else begin
      if (cfg_we) expected_len <= cfg_data;
      phase          <= phase_next;
      held_low       <= held_low_next;
      payload_left   <= payload_left_next;
      length_matched <= length_matched_next;
      cfg_applied    <= cfg_applied_next;
      frame_ready    <= frame_ready_next;
      busy           <= busy_next;
      error          <= error_next;
    end
  end

endmodule

>>> hdl/ccch_queue.sv
// short reply queue between the parser and the reply sender
module ccch_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ccch_pkg::reply_t push_data,
  input  logic             pop,
  output ccch_pkg::reply_t head,
  output logic             nonempty,
  output logic             full
);
  import ccch_pkg::*;

  reply_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_drop: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("reply pushed into a full queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

>>> hdl/ccch_back.sv
// reply sender: expands a queued descriptor into five output words
module ccch_back (
  input  logic             clk,
  input  logic             rst,
  input  ccch_pkg::reply_t head,
  input  logic             nonempty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       tx_byte,
  output logic             tx_last,
  output logic             start_frame
);
  import ccch_pkg::*;

  reply_t           cur;
  logic             active;
  logic [IDX_W-1:0] idx;
  logic             out_accept;
  logic             at_last;

  assign out_accept = active && !out_stall;
  assign at_last    = (idx == IDX_W'(REPLY_LEN - 1));
  assign pop        = nonempty && (!active || (out_accept && at_last));

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (pop) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (out_accept) begin
      if (at_last) active <= 1'b0;
      else         idx    <= idx + IDX_W'(1);
    end
  end

  always_comb begin
    case (idx)
      IDX_W'(0): tx_byte = cur.is_ack ? REPLY_ACK : REPLY_STATUS;
      IDX_W'(1): tx_byte = {{(8-STAT_W){1'b0}}, cur.bits};
      IDX_W'(3): tx_byte = {7'b0, cur.err};
      default:   tx_byte = 8'h00;
    endcase
  end

  assign out_valid   = active;
  assign tx_last     = at_last;
  assign start_frame = cur.start && (idx == '0);

`ifndef ASSERT_OFF
  a_hold_idx: assert property (@(posedge clk) disable iff (rst)
    (active && out_stall) |=> (active && $stable(idx)))
    else $error("reply word moved while stalled");
  a_start_first: assert property (@(posedge clk) disable iff (rst)
    (active && start_frame) |-> (tx_byte == REPLY_STATUS && !tx_last))
    else $error("start_frame off the first status word");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_W'(REPLY_LEN - 1))
    else $error("reply word index out of range");
`endif

endmodule

>>> hdl/control_channel_command_handler.sv
// top level of the control channel command handler
// Input channel (in_valid/in_stall, req_type, rx_byte): one word per cycle; a word
// with req_type high is a frame-done event, otherwise rx_byte is a control-link byte.
// Output channel (out_valid/out_stall, tx_byte, tx_last, start_frame): reply words,
// five per reply, tx_last on the fifth, start_frame on the first word of a triggered
// CONTROL reply.
// Config channel (cfg_valid/cfg_ready, cfg_data): writes expected_len; always ready; the
// user must see it written only while the block is idle; the block does not enforce it.
// The parser takes one word every cycle while in_stall is low and pushes one descriptor
// per finished message into a four-entry queue; the sender plays each descriptor out as
// five words, one per cycle while out_stall is low.
// The first reply word is offered once the descriptor has been registered in the queue
// and then loaded into the sender. Output bandwidth is five words per reply; in_stall
// rises only when the queue holds four replies not yet started.
// While out_stall is high the current word holds and the queue keeps filling.
// Reset (rst, synchronous) empties the queue, drops any word on offer, clears all
// flags and sets the expected length to 512. An unknown type byte halts parsing:
// later words are taken and dropped until reset.
module control_channel_command_handler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  tx_byte,
  output logic        tx_last,
  output logic        start_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import ccch_pkg::*;

  reply_t push_data;
  reply_t head;
  logic   push;
  logic   pop;
  logic   nonempty;
  logic   full;
  logic   in_accept;

  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  ccch_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .entry     (push_data)
  );

  ccch_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .nonempty  (nonempty),
    .full      (full)
  );

  ccch_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .nonempty    (nonempty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tx_byte     (tx_byte),
    .tx_last     (tx_last),
    .start_frame (start_frame)
  );

endmodule

>>> tb/tb_control_channel_command_handler.sv
// testbench for control_channel_command_handler: directed and random link traffic checked word by word
`timescale 1ns / 100ps

module tb_control_channel_command_handler;
  import ccch_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 370;
  localparam int CYCLE_LIMIT   = 3_000_000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_CTRL_LO, PH_CTRL_HI, PH_QRY_LO, PH_QRY_HI,
    PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_HALTED
  } link_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       start;
  } reply_word_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic        start_frame;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  // parser mirror
  link_phase_e link_phase;
  logic [7:0]  held_byte;
  logic [15:0] skip_left;
  logic [15:0] expected_len;
  logic        len_match;
  logic        cfg_applied;
  logic        frame_ready;
  logic        busy;
  logic        fault;

  reply_word_t expected_reply_q[$];
  int          failures;
  int          words_sent;
  int          cycle_count;
  logic        gaps_on;
  logic        frame_noise;

  control_channel_command_handler u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tx_byte     (tx_byte),
    .tx_last     (tx_last),
    .start_frame (start_frame),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** control_channel_command_handler: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_reply(input logic [39:0] bytes, input logic start);
    int k;
    reply_word_t w;
    for (k = 0; k < REPLY_LEN; k++) begin
      w.data  = bytes[39 - 8 * k -: 8];
      w.last  = (k == REPLY_LEN - 1);
      w.start = (k == 0) && start;
      expected_reply_q.push_back(w);
    end
  endfunction

  function automatic void push_status(input logic start);
    logic [7:0] bits;
    bits = busy ? 8'(STAT_BUSY) : 8'(STAT_READY);
    if (fault) bits |= 8'(STAT_ERROR);
    if (frame_ready) bits |= 8'(STAT_IMAGE);
    if (cfg_applied) bits |= 8'(STAT_CONFIG);
    push_reply({REPLY_STATUS, bits, 8'h00, {7'd0, fault}, 8'h00}, start);
  endfunction

  function automatic void push_ack();
    cfg_applied = len_match;
    fault = !len_match;
    link_phase = PH_IDLE;
    push_reply({REPLY_ACK, len_match ? 8'h00 : 8'h01, 8'h00,
                len_match ? 8'h00 : FAIL_ADDR[7:0],
                len_match ? 8'h00 : FAIL_ADDR[15:8]}, 1'b0);
  endfunction

  // advance the mirror by one accepted input word
  function automatic void parse_link_word(input logic frame_done, input logic [7:0] b);
    logic trig;
    if (link_phase == PH_HALTED) return;
    if (frame_done) begin
      frame_ready = 1'b1;
      busy = 1'b0;
      return;
    end
    trig = held_byte[CTRL_TRIGGER_BIT];
    case (link_phase)
      PH_IDLE: begin
        if (b == TYPE_CONTROL) link_phase = PH_CTRL_LO;
        else if (b == TYPE_QUERY) link_phase = PH_QRY_LO;
        else if (b == TYPE_CONFIG) link_phase = PH_LEN_LO;
        else link_phase = PH_HALTED;
      end
      PH_CTRL_LO: begin
        held_byte = b;
        link_phase = PH_CTRL_HI;
      end
      PH_CTRL_HI: begin
        // reset bit first, then trigger
        if (held_byte[CTRL_RESET_BIT]) begin
          cfg_applied = 1'b0;
          frame_ready = 1'b0;
          busy = 1'b0;
          fault = 1'b0;
        end
        if (trig) begin
          frame_ready = 1'b0;
          busy = 1'b1;
        end
        link_phase = PH_IDLE;
        push_status(trig);
      end
      PH_QRY_LO: link_phase = PH_QRY_HI;
      PH_QRY_HI: begin
        link_phase = PH_IDLE;
        push_status(1'b0);
      end
      PH_LEN_LO: begin
        held_byte = b;
        link_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        skip_left = {b, held_byte};
        len_match = (skip_left == expected_len);
        if (skip_left == 16'd0) push_ack();
        else link_phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 16'd0) push_ack();
      end
      default: link_phase = PH_HALTED;
    endcase
  endfunction

  always @(posedge clk) begin
    reply_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reply_q.size() == 0) begin
        $error("tx_byte: no word expected, got %h", tx_byte);
        failures++;
      end else begin
        w = expected_reply_q.pop_front();
        if (tx_byte !== w.data) begin
          $error("tx_byte: expected %h, got %h", w.data, tx_byte);
          failures++;
        end
        if (tx_last !== w.last) begin
          $error("tx_last: expected %b, got %b", w.last, tx_last);
          failures++;
        end
        if (start_frame !== w.start) begin
          $error("start_frame: expected %b, got %b", w.start, start_frame);
          failures++;
        end
      end
    end
  end

  // receiver stalls: quiet stretches broken by bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(20, 150))
        @(posedge clk);
      out_stall <= 1'b1;
      repeat (pick_gap() + 1) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic rt, input logic [7:0] b);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
    parse_link_word(rt, b);
  endtask

  // body word, sometimes preceded by a frame-done event
  task automatic body_byte(input logic [7:0] b);
    if (frame_noise && $urandom_range(0, 11) == 0) send_word(1'b1, 8'($urandom));
    send_word(1'b0, b);
  endtask

  task automatic send_config_header(input logic [15:0] len);
    send_word(1'b0, TYPE_CONFIG);
    body_byte(len[7:0]);
    body_byte(len[15:8]);
  endtask

  task automatic send_payload(input int n);
    repeat (n) body_byte(8'($urandom));
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_reply_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_expected_len(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    expected_len = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_status_replies();
    send_word(1'b0, TYPE_QUERY);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, TYPE_CONTROL);       // trigger only
    send_word(1'b0, 8'h02);
    send_word(1'b0, 8'h00);
    send_word(1'b1, 8'hA5);
    send_word(1'b0, TYPE_CONTROL);       // reset only, upper bits set
    send_word(1'b0, 8'hFD);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, TYPE_CONTROL);       // reset and trigger, frame done inside
    send_word(1'b0, 8'h03);
    send_word(1'b1, 8'h5A);
    send_word(1'b0, 8'h00);
  endtask

  // short lengths against the length register out of reset
  task automatic test_reset_length();
    settle_idle();
    send_config_header(16'h0000);
    send_config_header(16'd2);
    send_payload(2);
  endtask

  task automatic test_config_ack();
    settle_idle();
    write_expected_len(16'h0000);
    send_config_header(16'h0000);          // ack right after length
    settle_idle();
    write_expected_len(16'd3);
    send_config_header(16'd2);             // mismatch, frame done mid payload
    send_word(1'b0, 8'h11);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'h22);
    send_config_header(16'd3);             // register changes after the length
    send_word(1'b0, 8'h33);
    settle_idle();
    write_expected_len(16'd5);
    send_payload(2);
  endtask

  task automatic test_length_extremes();
    settle_idle();
    write_expected_len(16'hFFFF);
    send_config_header(16'h0000);          // zero length against the largest value
    send_word(1'b0, TYPE_QUERY);
    send_word(1'b0, 8'h5A);
    send_word(1'b0, 8'hA5);
  endtask

  task automatic test_random_traffic();
    int first_word;
    int msgs;
    int len;
    int r;
    first_word = words_sent;
    msgs = 0;
    frame_noise = 1'b1;
    while (words_sent - first_word < RANDOM_WORDS) begin
      if (msgs % 24 == 23) begin
        settle_idle();
        r = $urandom_range(0, 9);
        if (r == 0) write_expected_len(16'hFFFF);
        else if (r == 1) write_expected_len(16'($urandom));
        else write_expected_len(16'($urandom_range(0, 10)));
      end
      if (msgs % 16 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: send_word(1'b1, 8'($urandom));
        1, 2, 3: begin
          send_word(1'b0, TYPE_CONTROL);
          body_byte(8'($urandom));
          body_byte(8'($urandom));
        end
        4, 5, 6: begin
          send_word(1'b0, TYPE_QUERY);
          body_byte(8'($urandom));
          body_byte(8'($urandom));
        end
        default: begin
          if ($urandom_range(0, 1) && expected_len <= 16'd12) len = expected_len;
          else len = $urandom_range(0, 10);
          send_config_header(16'(len));
          send_payload(len);
        end
      endcase
      msgs++;
    end
    gaps_on = 1'b1;
  endtask

  // must run last: the block stays halted until reset
  task automatic test_unknown_type();
    logic [7:0] b;
    do b = 8'($urandom); while (b inside {TYPE_CONTROL, TYPE_QUERY, TYPE_CONFIG});
    send_word(1'b0, b);
    repeat (8) send_word($urandom_range(0, 3) == 0, 8'($urandom));
    send_word(1'b0, TYPE_QUERY);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'h00);
    send_word(1'b0, TYPE_CONTROL);
    send_word(1'b0, 8'h03);
    send_word(1'b0, 8'h00);
    repeat (8) send_word($urandom_range(0, 3) == 0, 8'($urandom));
  endtask

  initial begin
    failures     = 0;
    words_sent   = 0;
    cycle_count  = 0;
    gaps_on      = 1'b1;
    frame_noise  = 1'b0;
    link_phase   = PH_IDLE;
    held_byte    = 8'h00;
    skip_left    = 16'h0000;
    expected_len = CFG_LEN_RESET;
    len_match    = 1'b0;
    cfg_applied  = 1'b0;
    frame_ready  = 1'b0;
    busy         = 1'b0;
    fault        = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    req_type  <= 1'b0;
    rx_byte   <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_data  <= 16'h0000;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_status_replies();
    test_reset_length();
    test_config_ack();
    test_length_extremes();
    test_random_traffic();
    test_unknown_type();

    settle_idle();
    if (failures == 0)
      $display("** control_channel_command_handler: PASSED **");
    else
      $display("** control_channel_command_handler: FAILED **");
    $finish;
  end

endmodule

>>> control_channel_command_handler.f
hdl/ccch_pkg.sv
hdl/ccch_front.sv
hdl/ccch_queue.sv
hdl/ccch_back.sv
hdl/control_channel_command_handler.sv
tb/tb_control_channel_command_handler.sv
